FILE: hdl/cwslm_pkg.sv
// Shared constants and the result record type for the cross-window local maximum detector.
`default_nettype none

package cwslm_pkg;

   // Largest grid side that the line stores hold
   localparam int MAX_SIDE    = 128;
   localparam int COL_W       = $clog2(MAX_SIDE);
   localparam int SIDE_W      = 8;
   localparam int PIX_W       = 8;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

   // Result queue
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH) + 1;

   typedef struct packed {
      logic [COL_W-1:0] row_index;
      logic [COL_W-1:0] column_index;
      logic [PIX_W-1:0] cell_value;
      logic             is_peak;
      logic             last_of_run;
   } res_type;

endpackage

`default_nettype wire

FILE: hdl/cross_window_strict_local_max.sv
// Top level: four-neighbour strict local maximum detector over a raster pixel stream.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   req      | req_valid / req_stall  | req_pixel
//   rsp      | rsp_valid / rsp_stall  | rsp_row_index, rsp_column_index,
//            |                        | rsp_cell_value, rsp_is_peak, rsp_last_of_run
//   csr      | csr_wr_en              | csr_wr_data (grid side)
//
// One pixel is taken per cycle while req_stall is low; its results enter a four-entry
// queue at the same edge, and the first one is on rsp in the cycle after acceptance
// if the queue was empty. On the last row below row 0 each pixel yields two results and
// the queue drains one per cycle while rsp_stall is low, so there input is held back.
// req_stall rises while fewer than two queue entries are free.
// Reset clears the counters and the queue and sets the side to 128; the line stores are
// not cleared and need no clearing pass, so a pixel can be taken in the first cycle.
`default_nettype none

module cross_window_strict_local_max
   import cwslm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_wr_en,
   input  wire logic [SIDE_W-1:0]    csr_wr_data,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIX_W-1:0]     req_pixel,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [COL_W-1:0]          rsp_row_index,
   output logic [COL_W-1:0]          rsp_column_index,
   output logic [PIX_W-1:0]          rsp_cell_value,
   output logic                      rsp_is_peak,
   output logic                      rsp_last_of_run
);

   // Line stores
   logic [PIX_W-1:0]      older_mem [MAX_SIDE];
   logic [PIX_W-1:0]      newer_mem [MAX_SIDE];

   logic [SIDE_W-1:0]     side_ff;
   logic [SIDE_W-1:0]     side_eff;
   logic [COL_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [COL_W-1:0]      col_in_p1;

   logic [PIX_W-1:0]      center_ff;
   logic [PIX_W-1:0]      up_ff;
   logic [PIX_W-1:0]      right_ff;
   logic [PIX_W-1:0]      left_ff;

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  col_wrap;
   logic                  row_last;
   logic                  interior;
   logic                  peak;
   logic                  has_a, has_b;
   res_type               res_a, res_b;
   res_type               push0_data;
   logic [1:0]            n_push;

   res_type               fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_p1;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // Side register: zero acts as one, anything above the store depth as the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
      end
   end

   always_comb begin
      side_eff = side_ff;
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_ff > SIDE_RESET) begin
         side_eff = SIDE_RESET;
      end
   end

   // Raster position
   assign col_wrap = ({1'b0, col_ff} + SIDE_W'(1)) == side_eff;
   assign row_last = ({1'b0, row_ff} + SIDE_W'(1)) == side_eff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (req_fire) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + COL_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Read ahead at the column of the next transaction; writes only touch the current column
   assign col_in_p1 = col_in + COL_W'(1);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         newer_mem[col_ff] <= req_pixel;
         older_mem[col_ff] <= center_ff;
      end
      center_ff <= newer_mem[col_in];
      right_ff  <= newer_mem[col_in_p1];
      up_ff     <= older_mem[col_in];
   end

   // Left neighbour is the centre of the previous column
   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff <= center_ff;
      end
   end

   // Peak test on the cell one row above the incoming pixel
   assign interior = (row_ff >= COL_W'(2)) && (col_ff != '0)
                  && (({1'b0, col_ff} + SIDE_W'(2)) <= side_eff);
   assign peak     = interior && (center_ff > up_ff) && (center_ff > left_ff)
                  && (center_ff > right_ff) && (center_ff > req_pixel);

   assign has_a = row_ff != '0;
   assign has_b = row_last;

   always_comb begin
      res_a.row_index    = row_ff - COL_W'(1);
      res_a.column_index = col_ff;
      res_a.cell_value   = center_ff;
      res_a.is_peak      = peak;
      res_a.last_of_run  = !row_last;

      res_b.row_index    = row_ff;
      res_b.column_index = col_ff;
      res_b.cell_value   = req_pixel;
      res_b.is_peak      = 1'b0;
      res_b.last_of_run  = 1'b1;

      push0_data = has_a ? res_a : res_b;
      n_push     = req_fire ? ({1'b0, has_a} + {1'b0, has_b}) : 2'd0;
   end

   // Result queue
   assign wr_ptr_p1 = wr_ptr_ff + FIFO_PTR_W'(1);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (has_a || has_b) begin
            fifo_mem[wr_ptr_ff] <= push0_data;
         end
         if (has_a && has_b) begin
            fifo_mem[wr_ptr_p1] <= res_b;
         end
      end
   end

   assign count_in = count_ff + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(n_push);
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Hold off input unless two entries are free
   assign req_stall = count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2);

   assign rsp_valid        = count_ff != '0;
   assign rsp_row_index    = fifo_mem[rd_ptr_ff].row_index;
   assign rsp_column_index = fifo_mem[rd_ptr_ff].column_index;
   assign rsp_cell_value   = fifo_mem[rd_ptr_ff].cell_value;
   assign rsp_is_peak      = fifo_mem[rd_ptr_ff].is_peak;
   assign rsp_last_of_run  = fifo_mem[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire

FILE: hdl/cwslm_checker.sv
// Port-level checker for the local maximum detector and its bind to the top level.
`default_nettype none

module cwslm_checker
   import cwslm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [COL_W-1:0]  rsp_row_index,
   input wire logic [COL_W-1:0]  rsp_column_index,
   input wire logic [PIX_W-1:0]  rsp_cell_value,
   input wire logic              rsp_is_peak,
   input wire logic              rsp_last_of_run
);

   // Come out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty or input stalled after reset");

   // A peak is never on the top row or the left column
   a_peak_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_peak |-> rsp_row_index != '0 && rsp_column_index != '0)
      else $error("peak flagged on a border cell");

   // A transaction that is not last of its run has its partner already queued
   a_partner_queued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("second result of a pixel missing");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value)
                              && $stable(rsp_row_index) && $stable(rsp_column_index))
      else $error("stalled result changed");

endmodule

bind cross_window_strict_local_max cwslm_checker u_cwslm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_row_index    (rsp_row_index),
   .rsp_column_index (rsp_column_index),
   .rsp_cell_value   (rsp_cell_value),
   .rsp_is_peak      (rsp_is_peak),
   .rsp_last_of_run  (rsp_last_of_run)
);

`default_nettype wire

FILE: verif/local_max_checker.sv
// Checker for the local maximum detector: watches both channels, predicts each cell and compares.
`timescale 1ns / 1ps

module local_max_checker
   import cwslm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [SIDE_W-1:0] csr_wr_data,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [PIX_W-1:0]  req_pixel,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [COL_W-1:0]  rsp_row_index,
   input  wire logic [COL_W-1:0]  rsp_column_index,
   input  wire logic [PIX_W-1:0]  rsp_cell_value,
   input  wire logic              rsp_is_peak,
   input  wire logic              rsp_last_of_run,
   output int                     failures,
   output int                     pending,
   output int                     cells_checked,
   output int                     peaks_found
);

   logic [SIDE_W-1:0] side_setting;
   logic [PIX_W-1:0]  upper_row [MAX_SIDE];
   logic [PIX_W-1:0]  lower_row [MAX_SIDE];
   int unsigned       next_row;
   int unsigned       next_col;
   res_type           cells_due[$];
   int                fail_count = 0;
   int                cell_count = 0;
   int                peak_count = 0;
   int                pending_count = 0;

   assign failures      = fail_count;
   assign pending       = pending_count;
   assign cells_checked = cell_count;
   assign peaks_found   = peak_count;

   function automatic int unsigned usable_side(input logic [SIDE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return 32'(raw);
   endfunction

   // Work out the cells released by one pixel and advance the raster position
   function void predict_cells(input logic [PIX_W-1:0] below);
      int unsigned     side;
      int unsigned     r;
      int unsigned     c;
      logic [PIX_W-1:0] centre;
      res_type         emitted;
      side = usable_side(side_setting);
      r = next_row;
      c = next_col;
      if (r >= side || c >= side) begin
         r = 0;
         c = 0;
      end
      if (r >= 1) begin
         centre = lower_row[c];
         emitted.row_index    = COL_W'(r - 1);
         emitted.column_index = COL_W'(c);
         emitted.cell_value   = centre;
         emitted.is_peak      = 1'b0;
         // interior only: row 1..side-2 and column 1..side-2
         if (r >= 2 && r + 1 <= side && c >= 1 && c + 2 <= side)
            emitted.is_peak = (centre > upper_row[c]) && (centre > upper_row[c-1]) &&
                              (centre > lower_row[c+1]) && (centre > below);
         emitted.last_of_run  = (r + 1 != side);
         cells_due.push_back(emitted);
      end
      if (r + 1 == side) begin
         emitted.row_index    = COL_W'(r);
         emitted.column_index = COL_W'(c);
         emitted.cell_value   = below;
         emitted.is_peak      = 1'b0;
         emitted.last_of_run  = 1'b1;
         cells_due.push_back(emitted);
      end
      upper_row[c] = lower_row[c];
      lower_row[c] = below;
      c++;
      if (c >= side) begin
         c = 0;
         r++;
         if (r >= side) r = 0;
      end
      next_row = r;
      next_col = c;
   endfunction

   function void compare_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      res_type wanted;
      if (reset) begin
         side_setting = SIDE_RESET;
         next_row = 0;
         next_col = 0;
         cells_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cells_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction, expected none, actual row %0d col %0d",
                        $time, rsp_row_index, rsp_column_index);
            end else begin
               wanted = cells_due.pop_front();
               compare_field("row_index", 8'(wanted.row_index), 8'(rsp_row_index));
               compare_field("column_index", 8'(wanted.column_index), 8'(rsp_column_index));
               compare_field("cell_value", wanted.cell_value, rsp_cell_value);
               compare_field("is_peak", 8'(wanted.is_peak), 8'(rsp_is_peak));
               compare_field("last_of_run", 8'(wanted.last_of_run), 8'(rsp_last_of_run));
               cell_count++;
               if (wanted.is_peak) peak_count++;
            end
         end
         // a side write restarts the frame
         if (csr_wr_en) begin
            side_setting = csr_wr_data;
            next_row = 0;
            next_col = 0;
         end
         if (req_valid && !req_stall) predict_cells(req_pixel);
      end
      pending_count <= cells_due.size();
   end

endmodule

FILE: verif/tb_top.sv
// Testbench top: drives pixel frames and side settings into the detector and gives the verdict.
`timescale 1ns / 1ps

module tb_top
   import cwslm_pkg::*;
();

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 300;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [SIDE_W-1:0] csr_wr_data = '0;
   logic              req_valid   = 1'b0;
   logic [PIX_W-1:0]  req_pixel   = '0;
   logic              rsp_stall   = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [COL_W-1:0]  rsp_row_index;
   logic [COL_W-1:0]  rsp_column_index;
   logic [PIX_W-1:0]  rsp_cell_value;
   logic              rsp_is_peak;
   logic              rsp_last_of_run;

   int failures;
   int pending;
   int cells_checked;
   int peaks_found;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_asks   = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int cycle_count = 0;
   int pixels_sent = 0;
   int frames_sent = 0;

   always #1 clock = ~clock;

   cross_window_strict_local_max uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_is_peak      (rsp_is_peak),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   local_max_checker peak_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_is_peak      (rsp_is_peak),
      .rsp_last_of_run  (rsp_last_of_run),
      .failures         (failures),
      .pending          (pending),
      .cells_checked    (cells_checked),
      .peaks_found      (peaks_found)
   );

   // Receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served <= hold_asks;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d cells outstanding", cycle_count, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            idle_pct = 0;
            stall_pct <= 0;
         end
         1: begin
            idle_pct = 74;
            stall_pct <= 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct <= 74;
         end
         default: begin
            idle_pct = 22;
            stall_pct <= 22;
         end
      endcase
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // Hold the sender until every predicted cell has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_side(input logic [SIDE_W-1:0] value);
      drain_results();
      // first-row pixels leave nothing to wait for, so allow the pipeline to settle
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input int style);
      case (style)
         0: return PIX_W'($urandom_range(255));
         1: return PIX_W'($urandom_range(3));
         default: return $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   task automatic send_frame(input int unsigned total, input int style, input bit mid_pause);
      for (int unsigned k = 0; k < total; k++) begin
         if (mid_pause && k == total / 2) drain_results();
         push_pixel(pick_pixel(style));
      end
      frames_sent++;
   endtask

   initial begin
      logic [PIX_W-1:0]  peak_grid [9];
      logic [PIX_W-1:0]  tie_grid [9];
      logic [SIDE_W-1:0] side_code;
      int unsigned       eff_side;
      int unsigned       full_items;
      int unsigned       frame_items;
      int                frame_no;
      int                mode;
      int                pick;
      bit                force_write;
      bit                keep_side;

      peak_grid = '{8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254};
      tie_grid  = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd200, 8'd1, 8'd1, 8'd200, 8'd1};
      frame_no = 0;
      side_code = SIDE_RESET;
      force_write = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // reset side: the first row gives nothing
      push_pixel(8'hFF);
      push_pixel(8'h00);
      write_side(8'd1);
      push_pixel(8'h00);
      push_pixel(8'hFF);
      // zero acts as a side of one
      write_side(8'd0);
      push_pixel(8'hA5);
      write_side(8'd3);
      foreach (peak_grid[k]) push_pixel(peak_grid[k]);
      // equal value below the centre: no peak
      write_side(8'd3);
      foreach (tie_grid[k]) push_pixel(tie_grid[k]);

      while (pixels_sent < ITEM_TARGET) begin
         frame_no++;
         mode = (frame_no == 7) ? 0 : (frame_no / 3) % 4;
         set_idling(mode);
         keep_side = !force_write && frame_no != 4 && frame_no != 7 && frame_no != 11 &&
                     $urandom_range(9) < 3;
         if (!keep_side) begin
            if (frame_no == 4) begin
               side_code = 8'd128;
            end else if (frame_no == 11) begin
               side_code = 8'd255;
            end else if (frame_no == 7) begin
               side_code = 8'd8;
            end else begin
               pick = $urandom_range(99);
               if (pick < 4) side_code = 8'd0;
               else if (pick < 8) side_code = 8'd1;
               else if (pick < 12) side_code = 8'd2;
               else if (pick < 20) side_code = SIDE_W'($urandom_range(20, 11));
               else side_code = SIDE_W'($urandom_range(10, 3));
            end
            write_side(side_code);
         end
         eff_side = (side_code == 0) ? 1 : (side_code > MAX_SIDE) ? MAX_SIDE : side_code;
         full_items = eff_side * eff_side;
         if (side_code == 8'd128)
            frame_items = 2 * MAX_SIDE + 5;
         else if (side_code == 8'd255)
            frame_items = MAX_SIDE + 2;
         else if (full_items > 1 && $urandom_range(9) == 0)
            frame_items = $urandom_range(full_items - 1, 1);
         else
            frame_items = full_items;
         force_write = (frame_items != full_items);
         // long receiver hold-off while the sender keeps offering
         if (frame_no == 7) hold_asks <= hold_asks + 1;
         send_frame(frame_items, $urandom_range(2), $urandom_range(5) == 0);
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d pixels in %0d frames, sides 0 to 255 with restarts and wraps,",
               pixels_sent, frames_sent);
      $display("checking %0d emitted cells of which %0d were peaks", cells_checked, peaks_found);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
